// ===== rtl/core/wcac_pkg.sv =====
// Shared types and constants for the wrapping counter with alarm channels.
`default_nettype none
package wcac_pkg;

	localparam int unsigned NUM_CHANNELS = 8;
	localparam int unsigned CH_W = 3;
	localparam int unsigned CNT_W = 16;
	localparam logic [CNT_W-1:0] MAX_TOP = 16'hFFFF;

	typedef enum logic [2:0] {
		MODE_TICK   = 3'd0,
		MODE_SET    = 3'd1,
		MODE_CANCEL = 3'd2,
		MODE_LOAD   = 3'd3,
		MODE_START  = 3'd4,
		MODE_STOP   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_BUSY    = 2'd2,
		ST_LATE    = 2'd3
	} status_t;

	typedef enum logic {
		REG_TOP   = 1'b0,
		REG_GUARD = 1'b1
	} reg_idx_t;

endpackage
`default_nettype wire

// ===== rtl/core/wrapping_counter_alarm_channels.sv =====
// Top level: wrapping 16-bit counter with eight one-shot compare alarms.
`default_nettype none
// Each input word is a command (tick, set alarm, cancel alarm, set count,
// start, stop) and yields exactly one result word. A word is captured in an
// input register; from there a single pass of logic reads the counter,
// the alarm compare values and armed flags, updates them, and loads the
// result register, which raises out_valid. One word is taken per clock
// while in_stall is low. The output register decouples the sides: a new
// word is accepted while a result waits, and in_stall rises only when both
// the input and the output register are full and out_stall is high.
// The top value and the lateness margin are written through
// cfg_we/cfg_index/cfg_data and must only change while no command is in
// flight. A tick while stopped
// changes nothing. A set alarm computes the target (absolute, or count plus
// offset wrapping past top_value), then checks how far away it is; a late
// alarm is never armed and may fire at once (status late).
module wrapping_counter_alarm_channels
	import wcac_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CNT_W-1:0] cfg_data,
	// command words
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [2:0]       mode,
	input  wire logic [CH_W-1:0]  channel,
	input  wire logic [CNT_W-1:0] ticks,
	input  wire logic             absolute,
	input  wire logic             expire_when_late,
	// result words
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [CNT_W-1:0]      count_now,
	output logic [NUM_CHANNELS-1:0] fired_mask,
	output logic                  wrapped,
	output logic [1:0]            status
);

	// configuration registers
	logic [CNT_W-1:0] top_value_q;
	logic [CNT_W-1:0] margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_value_q <= MAX_TOP;
			margin_q    <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TOP:   top_value_q <= cfg_data;
				REG_GUARD: margin_q    <= cfg_data;
				default:   ;
			endcase
		end
	end

	// input register
	logic             valid_s1;
	mode_t            mode_s1;
	logic [CH_W-1:0]  channel_s1;
	logic [CNT_W-1:0] ticks_s1;
	logic             absolute_s1;
	logic             expire_s1;
	logic             adv_s1;

	// stage 1 moves on when the result register is empty or being drained
	assign adv_s1   = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1     <= mode_t'(mode);
			channel_s1  <= channel;
			ticks_s1    <= ticks;
			absolute_s1 <= absolute;
			expire_s1   <= expire_when_late;
		end
	end

	// timer state
	logic [CNT_W-1:0]        count_q;
	logic                    running_q;
	logic [NUM_CHANNELS-1:0] armed_q;
	// compare values are only looked at while armed, and arming writes them
	logic [CNT_W-1:0]        cmp_q [NUM_CHANNELS];

	// tick path
	logic [CNT_W-1:0]        tick_count;
	logic                    tick_wrap;
	logic [NUM_CHANNELS-1:0] tick_hit;

	assign tick_wrap  = count_q >= top_value_q;
	assign tick_count = tick_wrap ? '0 : count_q + 1'b1;

	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			tick_hit[i] = armed_q[i] && (cmp_q[i] == tick_count);
		end
	end

	// set-alarm path
	logic [CNT_W-1:0] half_top;
	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] sum_wrap;
	logic             no_wrap;
	logic [CNT_W-1:0] rel_target;
	logic [CNT_W-1:0] target;
	logic [CNT_W-1:0] pre_target;
	logic             pre_lt;
	logic [CNT_W+1:0] distance;
	logic             rel_early;
	logic [CNT_W-1:0] limit;
	logic             late;
	logic             late_fire;
	logic             ch_ok;
	logic             ticks_bad;

	assign half_top   = top_value_q >> 1;
	assign ticks_bad  = ticks_s1 > top_value_q;
	assign ch_ok      = {1'b0, channel_s1} < (CH_W+1)'(NUM_CHANNELS);

	// offset target, wrapping after top; a count already above top never wraps
	assign sum        = {1'b0, count_q} + {1'b0, ticks_s1};
	assign sum_wrap   = sum[CNT_W-1:0] - top_value_q - 1'b1;
	assign no_wrap    = (count_q > top_value_q) || (sum <= {1'b0, top_value_q});
	assign rel_target = no_wrap ? sum[CNT_W-1:0] : sum_wrap;
	assign target     = absolute_s1 ? ticks_s1 : rel_target;

	// distance from count to the tick before the target, modulo top + 1;
	// a negative result (count above top) counts as far too late
	assign pre_target = (target == '0) ? top_value_q : target - 1'b1;
	assign pre_lt     = pre_target < count_q;
	assign distance   = {2'b00, pre_target} - {2'b00, count_q}
		+ (pre_lt ? ({2'b00, top_value_q} + 1'b1) : '0);

	assign rel_early = ticks_s1 < half_top;

	always_comb begin
		if (absolute_s1) begin
			limit = (margin_q > top_value_q) ? '0 : top_value_q - margin_q;
		end else begin
			limit = rel_early ? half_top : top_value_q;
		end
	end

	assign late      = distance[CNT_W+1] || (distance[CNT_W:0] > {1'b0, limit});
	assign late_fire = absolute_s1 ? expire_s1 : rel_early;

	// next state and result
	logic [CNT_W-1:0]        count_d;
	logic                    running_d;
	logic [NUM_CHANNELS-1:0] armed_d;
	logic                    cmp_we;
	logic [NUM_CHANNELS-1:0] fired_d;
	logic                    wrapped_d;
	status_t                 status_d;

	always_comb begin
		count_d   = count_q;
		running_d = running_q;
		armed_d   = armed_q;
		cmp_we    = 1'b0;
		fired_d   = '0;
		wrapped_d = 1'b0;
		status_d  = ST_OK;
		unique case (mode_s1)
			MODE_TICK: begin
				if (running_q) begin
					count_d   = tick_count;
					wrapped_d = tick_wrap;
					fired_d   = tick_hit;
					armed_d   = armed_q & ~tick_hit;
				end
			end
			MODE_SET: begin
				priority if (!ch_ok || ticks_bad) begin
					status_d = ST_INVALID;
				end else if (armed_q[channel_s1]) begin
					status_d = ST_BUSY;
				end else begin
					cmp_we = 1'b1;
					if (late) begin
						status_d = ST_LATE;
						fired_d[channel_s1] = late_fire;
					end else begin
						armed_d[channel_s1] = 1'b1;
					end
				end
			end
			MODE_CANCEL: begin
				if (ch_ok) begin
					armed_d[channel_s1] = 1'b0;
				end else begin
					status_d = ST_INVALID;
				end
			end
			MODE_LOAD: begin
				if (ticks_bad) begin
					status_d = ST_INVALID;
				end else begin
					count_d = ticks_s1;
				end
			end
			MODE_START: running_d = 1'b1;
			MODE_STOP:  running_d = 1'b0;
			default:    status_d  = ST_INVALID;
		endcase
	end

	logic step;
	assign step = valid_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			running_q <= 1'b0;
			armed_q   <= '0;
		end else if (step) begin
			count_q   <= count_d;
			running_q <= running_d;
			armed_q   <= armed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && cmp_we) begin
			cmp_q[channel_s1] <= target;
		end
	end

	// result register
	logic [CNT_W-1:0]        count_now_q;
	logic [NUM_CHANNELS-1:0] fired_q;
	logic                    wrapped_q;
	status_t                 status_q;
	logic                    out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			count_now_q <= count_d;
			fired_q     <= fired_d;
			wrapped_q   <= wrapped_d;
			status_q    <= status_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign count_now  = count_now_q;
	assign fired_mask = fired_q;
	assign wrapped    = wrapped_q;
	assign status     = status_q;

	// a wrap always lands on zero
	a_wrap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wrapped |-> count_now == '0)
		else $error("wrap without zero count");

	// rejected commands never fire anything
	a_reject_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status_q == ST_INVALID || status_q == ST_BUSY) |-> fired_mask == '0)
		else $error("fire on rejected command");

	// a late alarm fires at most its own channel
	a_late_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_q == ST_LATE |-> $onehot0(fired_mask))
		else $error("late alarm fired several channels");

	// a channel that fired on a running tick is free afterwards
	a_fire_frees: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode_s1 == MODE_TICK && running_q |=> (armed_q & $past(tick_hit)) == '0)
		else $error("fired channel still armed");

	// input only backs up while both registers are occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("stall with free register");

endmodule
`default_nettype wire
